@@ rtl/trq_pkg.sv @@
package trq_pkg;

	// queue geometry (depth must be a power of two: indexes wrap by overflow)
	localparam int QUEUE_DEPTH  = 16;
	localparam int IDX_W        = $clog2(QUEUE_DEPTH);
	localparam int TYPE_BITS    = 4;
	localparam int ZOOM_BITS    = 5;
	localparam int PAYLOAD_BITS = 32;
	localparam int FILL_BITS    = 4;

	typedef logic [IDX_W-1:0] idx_t;

	// opcodes
	localparam logic [2:0] OP_ENQ   = 3'd0;
	localparam logic [2:0] OP_DEQ   = 3'd1;
	localparam logic [2:0] OP_PURGE = 3'd2;
	localparam logic [2:0] OP_QUERY = 3'd3;
	localparam logic [2:0] OP_CHK   = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_FULL       = 2'd1;
	localparam logic [1:0] ST_EMPTY      = 2'd2;
	localparam logic [1:0] ST_SUPPRESSED = 2'd3;

	typedef struct packed {
		logic [2:0]              opcode;
		logic [TYPE_BITS-1:0]    entry_type;
		logic [ZOOM_BITS-1:0]    entry_zoom;
		logic [PAYLOAD_BITS-1:0] entry_payload;
		logic                    running_valid;
		logic [TYPE_BITS-1:0]    running_type;
		logic [ZOOM_BITS-1:0]    running_zoom;
	} cmd_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [TYPE_BITS-1:0]    out_type;
		logic [ZOOM_BITS-1:0]    out_zoom;
		logic [PAYLOAD_BITS-1:0] out_payload;
		logic                    found;
		logic                    abort_request;
		logic [FILL_BITS-1:0]    fill_level;
	} result_t;

	typedef struct packed {
		logic [TYPE_BITS-1:0]    slot_type;
		logic [ZOOM_BITS-1:0]    slot_zoom;
		logic [PAYLOAD_BITS-1:0] slot_payload;
	} slot_t;

	function automatic idx_t idx_next(input idx_t i);
		return IDX_W'(i + IDX_W'(1));
	endfunction

endpackage

@@ rtl/trq_ram.sv @@
module trq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/task_ring_queue_with_purge_core.sv @@
// From accept to done: enqueue passes through S_PUSH and a non-empty dequeue
// through S_DEQ; empty dequeue, suppressed request and unknown opcode go to S_DONE;
// purge and query walk the queued slots in S_WALK, checked enqueue walks, then pushes.
// One command at a time: busy is high from accept until the command is through;
// the walk over the slot RAM reads one slot per cycle through its registered port.
// The result is shown for one cycle with done; the receiver cannot stall it.
// Reset (arst_n low, async): queue empty, map_type_q 0, slot contents left unset.
module task_ring_queue_with_purge_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  trq_pkg::cmd_t                         cmd,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [trq_pkg::TYPE_BITS-1:0]         cfg_data,
	output logic                                  done,
	output trq_pkg::result_t                      result
);

	import trq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_DEQ,
		S_WALK,
		S_DONE
	} state_t;

	state_t state_q;

	// queue pointers and walk pointers
	idx_t head_q, tail_q;
	idx_t rd_q, wr_q;
	logic pend_q;            // rdata holds the slot read last cycle

	logic [TYPE_BITS-1:0] map_type_q;
	logic [2:0]           op_q;

	// captured command payload
	logic [TYPE_BITS-1:0]    etype_q;
	logic [ZOOM_BITS-1:0]    ezoom_q;
	logic [PAYLOAD_BITS-1:0] epay_q;

	result_t result_q;
	logic    done_q;
	result_t res_init;       // result fields known at accept time

	// RAM port signals
	logic  ram_we;
	idx_t  ram_waddr, ram_raddr;
	slot_t ram_wdata, ram_rdata;

	logic accept;
	logic full;
	logic match;             // shared type comparator, used by every walk step
	logic purging;
	logic suppress_hit;
	logic dup_zoom;
	idx_t fill_cnt;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	assign full     = (idx_next(tail_q) == head_q);
	assign match    = (ram_rdata.slot_type == etype_q);
	assign purging  = (op_q != OP_QUERY);
	assign fill_cnt = IDX_W'(tail_q - head_q);

	// checked enqueue hits the running map-image task of the same type
	assign suppress_hit = cmd.running_valid && (cmd.running_type == cmd.entry_type)
		&& (cmd.entry_type == map_type_q);
	// same zoom as the runner: duplicate request, dropped
	assign dup_zoom = suppress_hit && (cmd.entry_zoom == cmd.running_zoom);

	// status and abort flag that are settled at accept
	always_comb begin
		res_init = '0;
		if ((cmd.opcode == OP_DEQ) && (head_q == tail_q)) begin
			res_init.status = ST_EMPTY;
		end else if (cmd.opcode == OP_CHK) begin
			if (dup_zoom) begin
				res_init.status = ST_SUPPRESSED;
			end else begin
				res_init.abort_request = suppress_hit;
			end
		end
	end

	// RAM control: walk compacts survivors to wr_q; push writes at tail.
	// Idle reads head so a dequeue finds the slot ready in the next cycle.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = '{slot_type: etype_q, slot_zoom: ezoom_q, slot_payload: epay_q};
		ram_raddr = head_q;
		unique case (state_q)
			S_WALK: begin
				ram_raddr = rd_q;
				ram_waddr = wr_q;
				ram_wdata = ram_rdata;
				ram_we    = pend_q && purging && !match;
			end
			S_PUSH: begin
				ram_we = !full;
			end
			default: begin
			end
		endcase
	end

	trq_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// command payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			etype_q <= cmd.entry_type;
			ezoom_q <= cmd.entry_zoom;
			epay_q  <= cmd.entry_payload;
		end
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_type_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			map_type_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			rd_q     <= '0;
			wr_q     <= '0;
			pend_q   <= 1'b0;
			op_q     <= OP_ENQ;
			result_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= (state_q == S_DONE);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= cmd.opcode;
						result_q <= res_init;
						rd_q     <= head_q;
						wr_q     <= head_q;
						pend_q   <= 1'b0;
						unique case (cmd.opcode)
							OP_ENQ: begin
								state_q <= S_PUSH;
							end
							OP_DEQ: begin
								if (head_q == tail_q) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_DEQ;
								end
							end
							OP_PURGE, OP_QUERY: begin
								state_q <= S_WALK;
							end
							OP_CHK: begin
								if (dup_zoom) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_WALK;
								end
							end
							default: begin
								// unknown opcode: report fill only
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_PUSH: begin
					if (full) begin
						result_q.status <= ST_FULL;
					end else begin
						tail_q <= idx_next(tail_q);
					end
					state_q <= S_DONE;
				end
				S_DEQ: begin
					result_q.out_type    <= ram_rdata.slot_type;
					result_q.out_zoom    <= ram_rdata.slot_zoom;
					result_q.out_payload <= ram_rdata.slot_payload;
					head_q               <= idx_next(head_q);
					state_q              <= S_DONE;
				end
				S_WALK: begin
					// issue next read while the previous slot is checked
					if (rd_q != tail_q) begin
						rd_q   <= idx_next(rd_q);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q) begin
						if (match) begin
							if (!purging) begin
								result_q.found <= 1'b1;
							end
						end else if (purging) begin
							wr_q <= idx_next(wr_q);
						end
					end
					if ((rd_q == tail_q) && !pend_q) begin
						if (purging) begin
							tail_q <= wr_q;
						end
						state_q <= (op_q == OP_CHK) ? S_PUSH : S_DONE;
					end
				end
				S_DONE: begin
					result_q.fill_level <= FILL_BITS'(fill_cnt);
					state_q             <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import trq_pkg::*;

	// opcodes 5..7 are unassigned: the block must treat them as a no-op
	localparam logic [2:0] OP_NOP_FIRST = 3'd5;
	localparam logic [2:0] OP_NOP_LAST  = 3'd7;

	localparam int RESET_CYCLES = 9;
	localparam int SETTLE_CYCLES = 20;
	localparam int STALL_LIMIT = 4000;   // cycles with no beat of any kind
	localparam int PHASE_CMDS = 130;

	typedef struct {
		cmd_t    c;
		bit      typed;   // 1: want holds a hand-written result
		result_t want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	cmd_t                 cmd = '0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [TYPE_BITS-1:0] cfg_data = '0;
	logic                 done;
	result_t              result;

	task_ring_queue_with_purge_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Queue predictor: the ring is kept as an ordered list of live slots.
	// Head is element 0; one ring slot stays empty, so at most depth-1 live.
	// ------------------------------------------------------------------
	slot_t                queued_slots[$];
	logic [TYPE_BITS-1:0] model_map_type = '0;
	result_t              pending_results[$];
	stim_row_t            stim_rows[$];

	int err_count = 0;
	int n_cmds = 0;
	int n_checked = 0;
	int n_cfg = 0;
	int n_empty = 0;
	int n_full = 0;
	int n_suppressed = 0;
	int n_aborts = 0;
	int n_hits = 0;
	int peak_fill = 0;

	function automatic logic [1:0] push_slot(input cmd_t c);
		if (queued_slots.size() >= QUEUE_DEPTH - 1)
			return ST_FULL;
		queued_slots.push_back('{slot_type: c.entry_type, slot_zoom: c.entry_zoom,
			slot_payload: c.entry_payload});
		return ST_OK;
	endfunction

	// remove every slot of one type, survivors keep their order
	function automatic void drop_type(input logic [TYPE_BITS-1:0] t);
		slot_t kept[$];
		foreach (queued_slots[i])
			if (queued_slots[i].slot_type != t)
				kept.push_back(queued_slots[i]);
		queued_slots = kept;
	endfunction

	function automatic result_t model_step(input cmd_t c);
		result_t r;
		logic    same_zoom_map;
		r = '0;
		same_zoom_map = 1'b0;
		case (c.opcode)
			OP_ENQ: r.status = push_slot(c);
			OP_DEQ: begin
				if (queued_slots.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.out_type = queued_slots[0].slot_type;
					r.out_zoom = queued_slots[0].slot_zoom;
					r.out_payload = queued_slots[0].slot_payload;
					void'(queued_slots.pop_front());
				end
			end
			OP_PURGE: drop_type(c.entry_type);
			OP_QUERY: begin
				foreach (queued_slots[i])
					if (queued_slots[i].slot_type == c.entry_type)
						r.found = 1'b1;
			end
			OP_CHK: begin
				// map-image request against a running map-image task:
				// same zoom is a duplicate, other zoom aborts the runner
				if (c.running_valid && c.running_type == c.entry_type &&
						c.entry_type == model_map_type) begin
					if (c.entry_zoom == c.running_zoom)
						same_zoom_map = 1'b1;
					else
						r.abort_request = 1'b1;
				end
				if (same_zoom_map) begin
					r.status = ST_SUPPRESSED;
				end else begin
					drop_type(c.entry_type);
					r.status = push_slot(c);
				end
			end
			default: ;
		endcase
		r.fill_level = FILL_BITS'(queued_slots.size());
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Command driver: fields change on the falling edge, the beat is
	// taken on the rising edge where start is high and busy is low.
	// ------------------------------------------------------------------
	task automatic issue_cmd(input cmd_t c, input bit typed, input result_t want);
		result_t pred;
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		pred = model_step(c);
		pending_results.push_back(typed ? want : pred);
		n_cmds++;
		if (pred.status == ST_EMPTY) n_empty++;
		if (pred.status == ST_FULL) n_full++;
		if (pred.status == ST_SUPPRESSED) n_suppressed++;
		if (pred.abort_request) n_aborts++;
		if (pred.found) n_hits++;
		if (queued_slots.size() > peak_fill) peak_fill = queued_slots.size();
	endtask

	// hold off new commands until every pending result is back
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic cmd_t mk_cmd(input logic [2:0] op, input logic [TYPE_BITS-1:0] et,
			input logic [ZOOM_BITS-1:0] ez, input logic [PAYLOAD_BITS-1:0] ep,
			input logic rv, input logic [TYPE_BITS-1:0] rt, input logic [ZOOM_BITS-1:0] rz);
		return '{opcode: op, entry_type: et, entry_zoom: ez, entry_payload: ep,
			running_valid: rv, running_type: rt, running_zoom: rz};
	endfunction

	function automatic result_t mk_res(input logic [1:0] st, input logic [TYPE_BITS-1:0] ot,
			input logic [ZOOM_BITS-1:0] oz, input logic [PAYLOAD_BITS-1:0] opay,
			input logic fnd, input logic ab, input logic [FILL_BITS-1:0] fl);
		return '{status: st, out_type: ot, out_zoom: oz, out_payload: opay,
			found: fnd, abort_request: ab, fill_level: fl};
	endfunction

	function automatic void add_row(input cmd_t c, input bit typed, input result_t want);
		stim_rows.push_back('{c: c, typed: typed, want: want});
	endfunction

	// ------------------------------------------------------------------
	// Result checker: one beat per done strobe, matched to the oldest
	// pending expectation. The receiver cannot stall, so no back-pressure.
	// ------------------------------------------------------------------
	task automatic report_field(input string fname, input logic [31:0] w, input logic [31:0] g);
		$display("%0t: mismatch on %s: expected %0h, got %0h", $time, fname, w, g);
		err_count++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing pending: got %h", $time, result);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (result.status !== want.status)
					report_field("status", 32'(want.status), 32'(result.status));
				if (result.out_type !== want.out_type)
					report_field("out_type", 32'(want.out_type), 32'(result.out_type));
				if (result.out_zoom !== want.out_zoom)
					report_field("out_zoom", 32'(want.out_zoom), 32'(result.out_zoom));
				if (result.out_payload !== want.out_payload)
					report_field("out_payload", want.out_payload, result.out_payload);
				if (result.found !== want.found)
					report_field("found", 32'(want.found), 32'(result.found));
				if (result.abort_request !== want.abort_request)
					report_field("abort_request", 32'(want.abort_request),
						32'(result.abort_request));
				if (result.fill_level !== want.fill_level)
					report_field("fill_level", 32'(want.fill_level), 32'(result.fill_level));
			end
		end
	end

	// watchdog: any beat (command, result or config) clears the count
	int stall_cycles = 0;
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles = stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog, no beat for %0d cycles", $time, STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int                   phase_map[4];
		int                   idle_pct[4];
		int                   pick;
		int                   enq_cut;
		cmd_t                 c;

		// Directed part. Map-image type is 0 (reset value) throughout.
		// empty queue: dequeue reports empty, query misses, purge is a no-op
		add_row(mk_cmd(OP_DEQ, '0, '0, '0, 1'b0, '0, '0), 1'b1,
			mk_res(ST_EMPTY, '0, '0, '0, 1'b0, 1'b0, '0));
		add_row(mk_cmd(OP_QUERY, '0, '0, '0, 1'b0, '0, '0), 1'b1,
			mk_res(ST_OK, '0, '0, '0, 1'b0, 1'b0, '0));
		add_row(mk_cmd(OP_PURGE, 4'd15, '0, '0, 1'b0, '0, '0), 1'b1,
			mk_res(ST_OK, '0, '0, '0, 1'b0, 1'b0, '0));
		// unassigned opcode with every other field at all-ones
		add_row(mk_cmd(OP_NOP_LAST, 4'd15, 5'd31, 32'hFFFF_FFFF, 1'b1, 4'd15, 5'd31), 1'b1,
			mk_res(ST_OK, '0, '0, '0, 1'b0, 1'b0, '0));
		// field extremes through enqueue and back out
		add_row(mk_cmd(OP_ENQ, 4'd15, 5'd31, 32'hFFFF_FFFF, 1'b1, 4'd15, 5'd31), 1'b1,
			mk_res(ST_OK, '0, '0, '0, 1'b0, 1'b0, 4'd1));
		add_row(mk_cmd(OP_ENQ, '0, '0, '0, 1'b0, '0, '0), 1'b1,
			mk_res(ST_OK, '0, '0, '0, 1'b0, 1'b0, 4'd2));
		add_row(mk_cmd(OP_DEQ, '0, '0, '0, 1'b0, '0, '0), 1'b1,
			mk_res(ST_OK, 4'd15, 5'd31, 32'hFFFF_FFFF, 1'b0, 1'b0, 4'd1));
		// checked enqueue: duplicate zoom is dropped, other zoom aborts
		add_row(mk_cmd(OP_CHK, '0, '0, 32'h1234_5678, 1'b1, '0, '0), 1'b1,
			mk_res(ST_SUPPRESSED, '0, '0, '0, 1'b0, 1'b0, 4'd1));
		add_row(mk_cmd(OP_CHK, '0, 5'd5, 32'hA5A5_A5A5, 1'b1, '0, 5'd31), 1'b1,
			mk_res(ST_OK, '0, '0, '0, 1'b0, 1'b1, 4'd1));
		// nothing running: would match, but is a plain purge plus enqueue
		add_row(mk_cmd(OP_CHK, '0, 5'd7, 32'h0BAD_F00D, 1'b0, '0, 5'd7), 1'b1,
			mk_res(ST_OK, '0, '0, '0, 1'b0, 1'b0, 4'd1));
		add_row(mk_cmd(OP_DEQ, '0, '0, '0, 1'b0, '0, '0), 1'b1,
			mk_res(ST_OK, '0, 5'd7, 32'h0BAD_F00D, 1'b0, 1'b0, '0));
		// fill to depth-1 with no map-image type in the queue
		for (int i = 1; i <= QUEUE_DEPTH - 1; i++)
			add_row(mk_cmd(OP_ENQ, TYPE_BITS'(i), ZOOM_BITS'(2 * i), $urandom(), 1'b0, '0, '0),
				1'b0, '0);
		add_row(mk_cmd(OP_ENQ, 4'd3, 5'd3, 32'h5A5A_0003, 1'b0, '0, '0), 1'b1,
			mk_res(ST_FULL, '0, '0, '0, 1'b0, 1'b0, 4'd15));
		// full even after purge: drop, abort still flagged
		add_row(mk_cmd(OP_CHK, '0, 5'd9, 32'h5555_AAAA, 1'b1, '0, 5'd3), 1'b1,
			mk_res(ST_FULL, '0, '0, '0, 1'b0, 1'b1, 4'd15));

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[i])
			issue_cmd(stim_rows[i].c, stim_rows[i].typed, stim_rows[i].want);

		// Random phases: map-image type at both extremes and two middle values;
		// sender gaps none / heavy / none / light
		phase_map[0] = 15;
		phase_map[1] = $urandom_range(14, 1);
		phase_map[2] = 0;
		phase_map[3] = $urandom_range(14, 1);
		idle_pct[0] = 0;
		idle_pct[1] = 62;
		idle_pct[2] = 0;
		idle_pct[3] = 17;

		for (int ph = 0; ph < 4; ph++) begin
			// config only while the block is idle
			drain_results();
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_data <= TYPE_BITS'(phase_map[ph]);
			do @(posedge clk); while (!cfg_ready);
			model_map_type = TYPE_BITS'(phase_map[ph]);
			n_cfg++;
			@(negedge clk);
			cfg_valid <= 1'b0;

			for (int k = 0; k < PHASE_CMDS; k++) begin
				if (k == PHASE_CMDS / 2 || $urandom_range(49) == 0)
					drain_results();
				while ($urandom_range(99) < idle_pct[ph]) begin
					@(negedge clk);
					start <= 1'b0;
				end

				// alternate fill-heavy and drain-heavy stretches so the
				// queue swings between empty and full
				enq_cut = ((k / 32) % 2 == 0) ? 45 : 15;
				pick = $urandom_range(99);
				if (pick < enq_cut) c.opcode = OP_ENQ;
				else if (pick < 55) c.opcode = OP_DEQ;
				else if (pick < 65) c.opcode = OP_PURGE;
				else if (pick < 75) c.opcode = OP_QUERY;
				else if (pick < 95) c.opcode = OP_CHK;
				else c.opcode = 3'($urandom_range(OP_NOP_LAST, OP_NOP_FIRST));

				// few distinct types so purge and query find matches
				case ($urandom_range(3))
					0: c.entry_type = model_map_type;
					1: c.entry_type = TYPE_BITS'($urandom_range(3));
					default: c.entry_type = TYPE_BITS'($urandom_range(15));
				endcase
				c.entry_zoom = ZOOM_BITS'($urandom_range(31));
				c.entry_payload = $urandom();
				c.running_valid = ($urandom_range(3) != 0);
				c.running_type = TYPE_BITS'($urandom_range(15));
				c.running_zoom = $urandom_range(1) ? c.entry_zoom : ZOOM_BITS'($urandom_range(31));
				// most checked enqueues hit the map-image path
				if (c.opcode == OP_CHK && $urandom_range(9) < 6) begin
					c.entry_type = model_map_type;
					c.running_type = model_map_type;
				end
				issue_cmd(c, 1'b0, '0);
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d commands over %0d map-type settings; %0d results checked.",
			n_cmds, n_cfg + 1, n_checked);
		$display("Seen: %0d empty dequeues, %0d full drops, %0d duplicates, %0d aborts,",
			n_empty, n_full, n_suppressed, n_aborts);
		$display("      %0d hits, peak fill %0d.", n_hits, peak_fill);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/trq_pkg.sv
rtl/trq_ram.sv
rtl/task_ring_queue_with_purge_core.sv
bench/testbench.sv
